// File: hdl/nrsh_pkg.sv
// Package for the nearest ray/segment hit core: item types and fixed widths.
// No dependencies; used by every module of the block.
package nrsh_pkg;

   // Q16.4 coordinates, fixed by the item format
   localparam int COORD_BITS = 20;
   localparam int COUNT_BITS = 9;
   localparam int SLOT_BITS  = 8;

   // Item action codes
   localparam logic ACT_STORE = 1'b0;
   localparam logic ACT_RAY   = 1'b1;

   typedef struct packed {
      logic                         action;
      logic [SLOT_BITS-1:0]         slot;
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic                         hit;
      logic signed [COORD_BITS-1:0] hit_x;
      logic signed [COORD_BITS-1:0] hit_y;
   } rsp_type;

   // Entry of the queue between front and back
   typedef struct packed {
      logic    is_ray;
      req_type item;
   } queue_entry_type;

endpackage

// File: hdl/nrsh_front.sv
// Front end: accepts items, classifies store vs ray, queues them (two entries).
// Depends on nrsh_pkg.
module nrsh_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  nrsh_pkg::req_type        req_data,
   output logic                     q_valid,
   output nrsh_pkg::queue_entry_type q_entry,
   input  logic                     q_pop
);
   import nrsh_pkg::*;

   queue_entry_type entry_ff [2];
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic            push;
   logic            pop;

   assign busy    = (cnt_ff == 2'd2);
   assign push    = start && !busy;
   assign pop     = q_pop && q_valid;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_entry = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // payload storage, classified on transfer
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff].is_ray <= (req_data.action == ACT_RAY);
         entry_ff[wr_ptr_ff].item   <= req_data;
      end
   end

endmodule

// File: hdl/nrsh_mul.sv
// Shift-add multiplier, one bit of b per cycle, unsigned operands.
// Depends on nrsh_pkg for the coordinate width.
module nrsh_mul (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [2*nrsh_pkg::COORD_BITS:0]       a,
   input  logic [nrsh_pkg::COORD_BITS-1:0]       b,
   output logic                                  done,
   output logic [3*nrsh_pkg::COORD_BITS:0]       product
);
   import nrsh_pkg::*;

   localparam int BW = COORD_BITS;
   localparam int PW = 3 * COORD_BITS + 1;
   localparam int NW = $clog2(BW + 1);

   logic [PW-1:0] acc_ff, acc_in;
   logic [PW-1:0] ash_ff, ash_in;
   logic [BW-1:0] bsh_ff, bsh_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;

   assign done    = done_ff;
   assign product = acc_ff;

   always_comb begin
      acc_in  = acc_ff;
      ash_in  = ash_ff;
      bsh_in  = bsh_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         ash_in = PW'(a);
         bsh_in = b;
         cnt_in = NW'(BW);
         run_in = 1'b1;
      end else if (run_ff) begin
         // add partial product for the current bit of b
         if (bsh_ff[0]) acc_in = acc_ff + ash_ff;
         ash_in = ash_ff << 1;
         bsh_in = bsh_ff >> 1;
         cnt_in = cnt_ff - NW'(1);
         if (cnt_ff == NW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      ash_ff <= ash_in;
      bsh_ff <= bsh_in;
   end

endmodule

// File: hdl/nrsh_div.sv
// Restoring divider, one quotient bit per cycle; quotient known to fit
// COORD_BITS. Depends on nrsh_pkg.
module nrsh_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [3*nrsh_pkg::COORD_BITS:0]  num,
   input  logic [2*nrsh_pkg::COORD_BITS:0]  den,
   output logic                             done,
   output logic [nrsh_pkg::COORD_BITS-1:0]  quo
);
   import nrsh_pkg::*;

   localparam int QW = COORD_BITS;
   localparam int PW = 3 * COORD_BITS + 1;
   localparam int NW = $clog2(QW + 1);

   logic [PW-1:0] rem_ff, rem_in;
   logic [PW-1:0] dsh_ff, dsh_in;
   logic [QW-1:0] q_ff, q_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic          ge;

   assign done = done_ff;
   assign quo  = q_ff;
   assign ge   = (rem_ff >= dsh_ff);

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = num;
         dsh_in = PW'(den) << (QW - 1);
         q_in   = '0;
         cnt_in = NW'(QW);
         run_in = 1'b1;
      end else if (run_ff) begin
         // trial subtract of the shifted divisor
         if (ge) rem_in = rem_ff - dsh_ff;
         q_in   = {q_ff[QW-2:0], ge};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - NW'(1);
         if (cnt_ff == NW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

endmodule

// File: hdl/nrsh_back.sv
// Back end: segment table, count register and the per-segment test sequencer.
// Depends on nrsh_pkg, nrsh_mul and nrsh_div.
module nrsh_back #(
   parameter int MAX_SEGMENTS = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  nrsh_pkg::queue_entry_type       q_entry,
   output logic                            q_pop,
   input  logic                            cfg_we,
   input  logic [nrsh_pkg::COUNT_BITS-1:0] cfg_data,
   output logic                            rsp_valid,
   output nrsh_pkg::rsp_type               rsp_data
);
   import nrsh_pkg::*;

   localparam int CB  = COORD_BITS;
   localparam int DW  = CB + 1;          // coordinate difference
   localparam int PL  = 2 * CB;          // product of two magnitudes
   localparam int SW  = 2 * CB + 2;      // signed cross products
   localparam int PA  = 2 * CB + 1;      // wide multiplier operand
   localparam int PW  = 3 * CB + 1;      // wide product
   localparam int SQW = 2 * CB + 1;      // squared distance
   localparam int AW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CW  = $clog2(MAX_SEGMENTS + 1);
   localparam int TW  = 4 * CB;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_DISP  = 10'b0000000010,
      ST_READ  = 10'b0000000100,
      ST_LOAD  = 10'b0000001000,
      ST_MUL   = 10'b0000010000,
      ST_CHECK = 10'b0000100000,
      ST_QMUL  = 10'b0001000000,
      ST_QDIV  = 10'b0010000000,
      ST_SQR   = 10'b0100000000,
      ST_NEXT  = 10'b1000000000
   } back_state_type;

   function automatic logic [CB-1:0] mag(input logic signed [DW-1:0] v);
      logic signed [DW-1:0] n;
      n = v[DW-1] ? -v : v;
      return n[CB-1:0];
   endfunction

   back_state_type state_ff, state_in;
   logic [2:0]              op_ff, op_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic [CW-1:0]           n_ff, n_in;
   logic [COUNT_BITS-1:0]   count_ff;
   logic                    launch_ff, launch_in;
   req_type                 item_ff, item_in;
   logic                    is_ray_ff, is_ray_in;
   logic [TW-1:0]           seg_mem [MAX_SEGMENTS];
   logic [TW-1:0]           rd_ff;
   logic signed [DW-1:0]    dx_ff, dx_in, dy_ff, dy_in;
   logic signed [DW-1:0]    ex_ff, ex_in, ey_ff, ey_in;
   logic signed [DW-1:0]    ox_ff, ox_in, oy_ff, oy_in;
   logic signed [SW-1:0]    den_ff, den_in, sn_ff, sn_in, tn_ff, tn_in;
   logic [PW-1:0]           prod_ff, prod_in;
   logic [CB-1:0]           qx_ff, qx_in, qy_ff, qy_in;
   logic [PL-1:0]           sq_ff, sq_in;
   logic                    found_ff, found_in;
   logic [SQW-1:0]          best_d_ff, best_d_in;
   logic signed [CB-1:0]    best_x_ff, best_x_in, best_y_ff, best_y_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   // datapath helpers
   logic                    mem_we;
   logic [AW-1:0]           mem_wa;
   logic signed [DW-1:0]    op_u, op_v;
   logic [PA-1:0]           mul_a;
   logic [CB-1:0]           mul_b;
   logic                    mul_start, mul_done;
   logic [PW-1:0]           mul_prod;
   logic                    div_start, div_done;
   logic [CB-1:0]           div_q;
   logic [PL-1:0]           plow;
   logic signed [SW-1:0]    sp;
   logic signed [SW-1:0]    dn, snn, tnn;
   logic                    miss;
   logic signed [CB-1:0]    wx0, wy0, wx1, wy1;
   logic signed [DW-1:0]    px, py;
   logic [SQW-1:0]          d2;

   assign q_pop     = (state_ff == ST_IDLE) && q_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign wx0 = rd_ff[TW-1 -: CB];
   assign wy0 = rd_ff[TW-CB-1 -: CB];
   assign wx1 = rd_ff[TW-2*CB-1 -: CB];
   assign wy1 = rd_ff[CB-1:0];

   // cross product operand pairs
   always_comb begin
      case (op_ff)
         3'd0: begin op_u = dx_ff; op_v = ey_ff; end
         3'd1: begin op_u = ex_ff; op_v = dy_ff; end
         3'd2: begin op_u = dx_ff; op_v = oy_ff; end
         3'd3: begin op_u = dy_ff; op_v = ox_ff; end
         3'd4: begin op_u = ex_ff; op_v = oy_ff; end
         3'd5: begin op_u = ey_ff; op_v = ox_ff; end
         default: begin op_u = '0; op_v = '0; end
      endcase
   end

   // multiplier operand select
   always_comb begin
      case (state_ff)
         ST_QMUL: begin
            mul_a = tn_ff[PA-1:0];
            mul_b = (op_ff == 3'd0) ? mag(dx_ff) : mag(dy_ff);
         end
         ST_SQR: begin
            mul_a = (op_ff == 3'd0) ? PA'(qx_ff) : PA'(qy_ff);
            mul_b = (op_ff == 3'd0) ? qx_ff : qy_ff;
         end
         default: begin
            mul_a = PA'(mag(op_u));
            mul_b = mag(op_v);
         end
      endcase
   end

   assign mul_start = launch_ff && (state_ff == ST_MUL || state_ff == ST_QMUL ||
                                    state_ff == ST_SQR);
   assign div_start = launch_ff && (state_ff == ST_QDIV);

   nrsh_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   nrsh_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (prod_ff),
      .den   (den_ff[PA-1:0]),
      .done  (div_done),
      .quo   (div_q)
   );

   // signed cross product and normalized test values
   assign plow = mul_prod[PL-1:0];
   assign sp   = (op_u[DW-1] ^ op_v[DW-1]) ? -$signed({2'b00, plow})
                                           : $signed({2'b00, plow});
   assign dn   = den_ff[SW-1] ? -den_ff : den_ff;
   assign snn  = den_ff[SW-1] ? -sn_ff : sn_ff;
   assign tnn  = den_ff[SW-1] ? -tn_ff : tn_ff;
   assign miss = (den_ff == '0) || snn[SW-1] || tnn[SW-1] || (snn > dn) || (tnn > dn);

   // hit point and squared distance
   assign px = DW'(item_ff.start_x) + (dx_ff[DW-1] ? -$signed({1'b0, qx_ff})
                                                   : $signed({1'b0, qx_ff}));
   assign py = DW'(item_ff.start_y) + (dy_ff[DW-1] ? -$signed({1'b0, qy_ff})
                                                   : $signed({1'b0, qy_ff}));
   assign d2 = {1'b0, sq_ff} + {1'b0, plow};

   assign mem_we = (state_ff == ST_DISP) && !is_ray_ff &&
                   (32'(item_ff.slot) < 32'(MAX_SEGMENTS));
   assign mem_wa = AW'(item_ff.slot);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      launch_in    = 1'b0;
      item_in      = item_ff;
      is_ray_in    = is_ray_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      den_in       = den_ff;
      sn_in        = sn_ff;
      tn_in        = tn_ff;
      prod_in      = prod_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      sq_in        = sq_ff;
      found_in     = found_ff;
      best_d_in    = best_d_ff;
      best_x_in    = best_x_ff;
      best_y_in    = best_y_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               item_in   = q_entry.item;
               is_ray_in = q_entry.is_ray;
               state_in  = ST_DISP;
            end
         end
         ST_DISP: begin
            // store is written by mem_we; a ray starts the segment sweep, or answers a miss when the count is zero
            idx_in    = '0;
            found_in  = 1'b0;
            best_d_in = '0;
            best_x_in = '0;
            best_y_in = '0;
            if (32'(count_ff) > 32'(MAX_SEGMENTS)) n_in = CW'(MAX_SEGMENTS);
            else n_in = CW'(count_ff);
            dx_in = DW'(item_ff.end_x) - DW'(item_ff.start_x);
            dy_in = DW'(item_ff.end_y) - DW'(item_ff.start_y);
            if (!is_ray_ff) begin
               state_in = ST_IDLE;
            end else if (count_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            ex_in     = DW'(wx1) - DW'(wx0);
            ey_in     = DW'(wy1) - DW'(wy0);
            ox_in     = DW'(item_ff.start_x) - DW'(wx0);
            oy_in     = DW'(item_ff.start_y) - DW'(wy0);
            op_in     = 3'd0;
            launch_in = 1'b1;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            if (mul_done) begin
               case (op_ff)
                  3'd0: den_in = sp;
                  3'd1: den_in = den_ff - sp;
                  3'd2: sn_in  = sp;
                  3'd3: sn_in  = sn_ff - sp;
                  3'd4: tn_in  = sp;
                  default: tn_in = tn_ff - sp;
               endcase
               if (op_ff == 3'd5) begin
                  state_in = ST_CHECK;
               end else begin
                  op_in     = op_ff + 3'd1;
                  launch_in = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            if (miss) begin
               state_in = ST_NEXT;
            end else begin
               tn_in     = tnn;
               den_in    = dn;
               op_in     = 3'd0;
               launch_in = 1'b1;
               state_in  = ST_QMUL;
            end
         end
         ST_QMUL: begin
            if (mul_done) begin
               prod_in   = mul_prod;
               launch_in = 1'b1;
               state_in  = ST_QDIV;
            end
         end
         ST_QDIV: begin
            if (div_done) begin
               launch_in = 1'b1;
               if (op_ff == 3'd0) begin
                  qx_in    = div_q;
                  op_in    = 3'd1;
                  state_in = ST_QMUL;
               end else begin
                  qy_in    = div_q;
                  op_in    = 3'd0;
                  state_in = ST_SQR;
               end
            end
         end
         ST_SQR: begin
            if (mul_done) begin
               if (op_ff == 3'd0) begin
                  sq_in     = plow;
                  op_in     = 3'd1;
                  launch_in = 1'b1;
               end else begin
                  // keep the nearest; ties keep the earlier segment
                  if (!found_ff || d2 < best_d_ff) begin
                     found_in  = 1'b1;
                     best_d_in = d2;
                     best_x_in = px[CB-1:0];
                     best_y_in = py[CB-1:0];
                  end
                  state_in = ST_NEXT;
               end
            end
         end
         ST_NEXT: begin
            if (idx_ff + CW'(1) == n_ff) begin
               rsp_valid_in      = 1'b1;
               rsp_data_in.hit   = found_ff;
               rsp_data_in.hit_x = best_x_ff;
               rsp_data_in.hit_y = best_y_ff;
               state_in          = ST_IDLE;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_we) count_ff <= cfg_data;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      n_ff        <= n_in;
      item_ff     <= item_in;
      is_ray_ff   <= is_ray_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      ex_ff       <= ex_in;
      ey_ff       <= ey_in;
      ox_ff       <= ox_in;
      oy_ff       <= oy_in;
      den_ff      <= den_in;
      sn_ff       <= sn_in;
      tn_ff       <= tn_in;
      prod_ff     <= prod_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      sq_ff       <= sq_in;
      found_ff    <= found_in;
      best_d_ff   <= best_d_in;
      best_x_ff   <= best_x_in;
      best_y_ff   <= best_y_in;
      rsp_data_ff <= rsp_data_in;
   end

   // segment table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         seg_mem[mem_wa] <= {item_ff.start_x, item_ff.start_y,
                             item_ff.end_x, item_ff.end_y};
      end
      rd_ff <= seg_mem[idx_ff[AW-1:0]];
   end

endmodule

// File: hdl/nearest_ray_segment_hit_core.sv
// Top level of the nearest ray/segment hit core: front queue plus back sequencer.
// Depends on nrsh_pkg, nrsh_front and nrsh_back.
//
//   channel  | ports                                 | flow
//   request  | start, busy, req_data                 | transfer when start & !busy
//   response | rsp_valid, rsp_data                   | one-cycle strobe, not stallable
//   csr      | csr_valid, csr_ready, csr_wdata       | transfer when valid & ready
//
// A store passes through ST_DISP in the back end. A ray tests each segment
// with six cross-product multiplies; on a hit it adds two multiply/divide
// pairs for the hit point and two squarings, all on the bit-serial units.
// Up to two items wait in the front queue; busy is high while it is full.
// Synchronous reset clears control state and segment_count; table content is
// undefined until stored.
module nearest_ray_segment_hit_core #(
   parameter int MAX_SEGMENTS = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  nrsh_pkg::req_type               req_data,
   output logic                            rsp_valid,
   output nrsh_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [nrsh_pkg::COUNT_BITS-1:0] csr_wdata
);
   import nrsh_pkg::*;

   logic            q_valid;
   logic            q_pop;
   queue_entry_type q_entry;

   // register writes are to be made only while idle; the block does not enforce it
   assign csr_ready = 1'b1;

   nrsh_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_entry  (q_entry),
      .q_pop    (q_pop)
   );

   nrsh_back #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .cfg_we    (csr_valid && csr_ready),
      .cfg_data  (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hdl/nrsh_checker.sv
// Port-level checks for the nearest ray/segment hit core, bound to the top.
// Depends on nrsh_pkg.
module nrsh_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            busy,
   input logic                            rsp_valid,
   input nrsh_pkg::rsp_type               rsp_data
);
   import nrsh_pkg::*;

   // no response and busy low right after reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !busy)
      else $error("response or busy right after reset");

   // a response is never directly followed by another response
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back responses");

   // a miss reports the origin point
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.hit_x == '0 && rsp_data.hit_y == '0)
      else $error("miss with nonzero point");

endmodule

bind nearest_ray_segment_hit_core nrsh_checker u_nrsh_checker (.*);
